/* rtl/core/two_class_priority_queue_top_macros.svh */
// Assertion macros for the two-class priority queue.
// Included by the top level; depends on nothing else.
`ifndef TWO_CLASS_PRIORITY_QUEUE_TOP_MACROS_SVH
`define TWO_CLASS_PRIORITY_QUEUE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is held.
`define TCPQ_ASSERT_IMPL(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is held.
`define TCPQ_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TCPQ_ASSERT_IMPL(lbl, ck, rstn, ante, cons)
`define TCPQ_ASSERT_NEXT(lbl, ck, rstn, ante, cons)
`endif
`endif

/* rtl/core/tcpq_pkg.sv */
// Package for the two-class priority queue: codes, widths and FSM type.
// Used by two_class_priority_queue_top; depends on nothing.
`default_nettype none
package tcpq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned ID_W      = 32;
  localparam int unsigned STATUS_W  = 2;

  // Operation codes carried in the input tuser.
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Entry classes.
  localparam logic CLS_URGENT = 1'b0;
  localparam logic CLS_NORMAL = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_READ
  } tcpq_state_t;

endpackage
`default_nettype wire

/* rtl/core/two_class_priority_queue_top.sv */
// Two-class priority queue: one ring memory per class with pointers and counts.
// Depends on tcpq_pkg and two_class_priority_queue_top_macros.svh.
// An enqueue beat (tuser[0]=0) has its result registered at once. A dequeue
// beat that finds an entry first reads the head from the class ring, a
// synchronous memory with a registered read port, and the read data goes to
// the result register the next cycle. A dequeue on an empty queue has its
// result registered at once. A new beat is taken while the previous result
// waits, as long as that result register is freed at the same edge; a stalled
// output therefore holds off the input. No clearing pass follows reset:
// entries are only read after being written.
`default_nettype none
`include "two_class_priority_queue_top_macros.svh"
module two_class_priority_queue_top
  import tcpq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input beats.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] entry_id
  input  wire logic [1:0]  in_tuser,   // [0] opcode, [1] urgency
  // Result beats.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] served_id
  output logic [2:0]       out_tuser   // [1:0] status, [2] served_urgency
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  // Ring memories, one per class.
  logic [ID_W-1:0] urg_mem [DEPTH];
  logic [ID_W-1:0] nrm_mem [DEPTH];
  logic [ID_W-1:0] urg_rdata_r;
  logic [ID_W-1:0] nrm_rdata_r;

  // Ring pointers and occupancy counts.
  logic [PTR_W-1:0] urg_rp_r, urg_rp_nxt, urg_wp_r, urg_wp_nxt;
  logic [PTR_W-1:0] nrm_rp_r, nrm_rp_nxt, nrm_wp_r, nrm_wp_nxt;
  logic [CNT_W-1:0] urg_cnt_r, urg_cnt_nxt, nrm_cnt_r, nrm_cnt_nxt;

  tcpq_state_t state_r, state_nxt;
  logic        rd_cls_r, rd_cls_nxt;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;
  logic                out_cls_r, out_cls_nxt;

  logic in_beat;
  logic in_opcode, in_urgency;
  logic urg_full, nrm_full, urg_empty, nrm_empty;
  logic urg_wr, nrm_wr, urg_rd, nrm_rd;
  logic load_out;

  assign in_opcode  = in_tuser[0];
  assign in_urgency = in_tuser[1];
  assign in_beat    = in_tvalid && in_tready;
  assign urg_full   = (urg_cnt_r == CNT_FULL);
  assign nrm_full   = (nrm_cnt_r == CNT_FULL);
  assign urg_empty  = (urg_cnt_r == '0);
  assign nrm_empty  = (nrm_cnt_r == '0);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_beat && in_opcode == OP_DEQ && !(urg_empty && nrm_empty)) begin
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs of the FSM.
  always_comb begin
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE:  in_tready = !out_valid_r || out_tready;
      S_READ:  in_tready = 1'b0;
      default: in_tready = 1'b0;
    endcase
  end

  // Memory accesses decided by the accepted beat.
  assign urg_wr = in_beat && in_opcode == OP_ENQ && in_urgency == CLS_URGENT && !urg_full;
  assign nrm_wr = in_beat && in_opcode == OP_ENQ && in_urgency == CLS_NORMAL && !nrm_full;
  assign urg_rd = in_beat && in_opcode == OP_DEQ && !urg_empty;
  assign nrm_rd = in_beat && in_opcode == OP_DEQ && urg_empty && !nrm_empty;

  // Pointer and count updates.
  always_comb begin
    urg_rp_nxt  = urg_rd ? ptr_inc(urg_rp_r) : urg_rp_r;
    urg_wp_nxt  = urg_wr ? ptr_inc(urg_wp_r) : urg_wp_r;
    nrm_rp_nxt  = nrm_rd ? ptr_inc(nrm_rp_r) : nrm_rp_r;
    nrm_wp_nxt  = nrm_wr ? ptr_inc(nrm_wp_r) : nrm_wp_r;
    urg_cnt_nxt = urg_cnt_r;
    nrm_cnt_nxt = nrm_cnt_r;
    if (urg_wr) begin
      urg_cnt_nxt = urg_cnt_r + CNT_W'(1);
    end else if (urg_rd) begin
      urg_cnt_nxt = urg_cnt_r - CNT_W'(1);
    end
    if (nrm_wr) begin
      nrm_cnt_nxt = nrm_cnt_r + CNT_W'(1);
    end else if (nrm_rd) begin
      nrm_cnt_nxt = nrm_cnt_r - CNT_W'(1);
    end
    rd_cls_nxt = nrm_rd ? CLS_NORMAL : (urg_rd ? CLS_URGENT : rd_cls_r);
  end

  // Result register: immediate results in idle, read data after a fetch.
  always_comb begin
    load_out       = 1'b0;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_cls_nxt    = out_cls_r;
    if (state_r == S_READ) begin
      load_out       = 1'b1;
      out_status_nxt = ST_OK;
      out_id_nxt     = (rd_cls_r == CLS_NORMAL) ? nrm_rdata_r : urg_rdata_r;
      out_cls_nxt    = rd_cls_r;
    end else if (in_beat && !(urg_rd || nrm_rd)) begin
      load_out    = 1'b1;
      out_id_nxt  = '0;
      out_cls_nxt = 1'b0;
      if (in_opcode == OP_DEQ) begin
        out_status_nxt = ST_EMPTY;
      end else if (in_urgency == CLS_URGENT) begin
        out_status_nxt = urg_full ? ST_FULL : ST_OK;
      end else begin
        out_status_nxt = nrm_full ? ST_FULL : ST_OK;
      end
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      urg_rp_r    <= '0;
      urg_wp_r    <= '0;
      nrm_rp_r    <= '0;
      nrm_wp_r    <= '0;
      urg_cnt_r   <= '0;
      nrm_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      urg_rp_r    <= urg_rp_nxt;
      urg_wp_r    <= urg_wp_nxt;
      nrm_rp_r    <= nrm_rp_nxt;
      nrm_wp_r    <= nrm_wp_nxt;
      urg_cnt_r   <= urg_cnt_nxt;
      nrm_cnt_r   <= nrm_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_cls_r     <= rd_cls_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_cls_r    <= out_cls_nxt;
  end

  // Urgent ring memory, one write and one registered read port.
  always_ff @(posedge clk) begin
    if (urg_wr) begin
      urg_mem[urg_wp_r] <= in_tdata;
    end
    if (urg_rd) begin
      urg_rdata_r <= urg_mem[urg_rp_r];
    end
  end

  // Normal ring memory, one write and one registered read port.
  always_ff @(posedge clk) begin
    if (nrm_wr) begin
      nrm_mem[nrm_wp_r] <= in_tdata;
    end
    if (nrm_rd) begin
      nrm_rdata_r <= nrm_mem[nrm_rp_r];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_id_r;
  assign out_tuser  = {out_cls_r, out_status_r};

  // The result register is always free when fetched data arrives.
  `TCPQ_ASSERT_IMPL(a_read_slot_free, clk, rst_n, state_r == S_READ, !out_valid_r)
  // Occupancy never exceeds the ring depth.
  `TCPQ_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1,
                    urg_cnt_r <= CNT_FULL && nrm_cnt_r <= CNT_FULL)
  // An enqueue into a full urgent ring leaves its count unchanged.
  `TCPQ_ASSERT_NEXT(a_full_drop, clk, rst_n,
                    in_beat && in_opcode == OP_ENQ && in_urgency == CLS_URGENT && urg_full,
                    $stable(urg_cnt_r))
  // A normal entry is only fetched while no urgent entry is held.
  `TCPQ_ASSERT_IMPL(a_urgent_first, clk, rst_n, nrm_rd, urg_empty)

endmodule
`default_nettype wire
